// ===== rtl/gcl_pkg.sv =====
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared types and constants of the gcd / lcm unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gcl_pkg;

    // width of the operand and result fields on the stream ports
    localparam int DATA_WIDTH = 32;

    // operation select carried in s_tuser
    localparam logic MODE_GCD = 1'b0;
    localparam logic MODE_LCM = 1'b1;

    // control of the shared add / subtract unit
    typedef struct packed {
        logic sub;
    } alu_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/gcl_alu.sv =====
// ----------------------------------------------------------------------------
// gcl_alu
// Shared adder / subtractor used by every step of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_alu #(
    parameter int WIDTH = 33
) (
    input  gcl_pkg::alu_ctl_t ctl,
    input  logic [WIDTH-1:0]  op_a,
    input  logic [WIDTH-1:0]  op_b,
    output logic [WIDTH-1:0]  sum,
    output logic              carry
);
    import gcl_pkg::*;

    logic [WIDTH-1:0] op_b_inv;

    assign op_b_inv = ctl.sub ? ~op_b : op_b;

    // on a subtract, carry high means op_a >= op_b
    assign {carry, sum} = {1'b0, op_a} + {1'b0, op_b_inv} + {{WIDTH{1'b0}}, ctl.sub};

endmodule

`default_nettype wire

// ===== rtl/gcd_lcm_unit.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor or least common multiple of two unsigned operands.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tdata carries first_operand (bits 31:0) and
// second_operand (bits 63:32); s_tuser carries the mode, 0 for the divisor
// and 1 for the multiple. Operands are taken modulo 2^OPERAND_WIDTH.
// Output channel m_*: m_tdata carries result_value, m_tuser the overflow
// flag. An lcm too wide for OPERAND_WIDTH bits gives all ones and overflow.
// Steps: a load, then a binary gcd of one compare-subtract or shift per
// cycle, then for an lcm a restoring division (a / gcd) and a shift-add
// multiply (quotient * b), then the output register. All steps run
// through the one shared adder, so one item is in work at a time and
// s_tready is low until it finishes.
// The finished result waits in the output register; a new item is accepted
// while it waits, and a stalled receiver only holds the next result back.
// Reset clears the sequencer and m_tvalid; an item in work is dropped and no result is made up.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [2*gcl_pkg::DATA_WIDTH-1:0] s_tdata,  // first_operand, second_operand
    input  logic                           s_tuser,  // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gcl_pkg::DATA_WIDTH-1:0]   m_tdata,  // result_value
    output logic                           m_tuser   // overflow
);
    import gcl_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_MUL,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic           m_tvalid_reg, m_tvalid_next;

    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [W-1:0]   opa_reg, opa_next;
    logic [W-1:0]   opb_reg, opb_next;
    logic [W-1:0]   g_reg, g_next;
    logic [W-1:0]   res_reg, res_next;
    logic           ovf_reg, ovf_next;
    logic           mode_reg, mode_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [KW-1:0]  cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic           out_ovf_reg, out_ovf_next;

    alu_ctl_t       alu_ctl;
    logic [W:0]     alu_a;
    logic [W:0]     alu_b;
    logic [W:0]     alu_sum;
    logic           alu_carry;

    logic [W-1:0]   gcd_val;
    logic [W:0]     mul_sum;
    logic           out_free;

    gcl_alu #(
        .WIDTH (W + 1)
    ) u_alu (
        .ctl   (alu_ctl),
        .op_a  (alu_a),
        .op_b  (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ovf_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // one of a, b is zero when this is used, so the or is the other one
    assign gcd_val  = (a_reg | b_reg) << k_reg;
    assign mul_sum  = a_reg[0] ? alu_sum : {1'b0, b_reg};

    always_comb
    begin
        alu_ctl.sub = 1'b1;
        alu_a       = {1'b0, a_reg};
        alu_b       = {1'b0, b_reg};
        case (state_reg)
            S_DIV:
            begin
                // remainder in b, dividend bits shifted out of a
                alu_a = {b_reg, a_reg[W-1]};
                alu_b = {1'b0, g_reg};
            end
            S_MUL:
            begin
                // high half in b, multiplier in a
                alu_ctl.sub = 1'b0;
                alu_a       = {1'b0, b_reg};
                alu_b       = {1'b0, opb_reg};
            end
            default:
            begin
                alu_ctl.sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        g_next        = g_reg;
        res_next      = res_reg;
        ovf_next      = ovf_reg;
        mode_next     = mode_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        out_data_next = out_data_reg;
        out_ovf_next  = out_ovf_reg;

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    opa_next   = W'(s_tdata[DATA_WIDTH-1:0]);
                    opb_next   = W'(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
                    a_next     = W'(s_tdata[DATA_WIDTH-1:0]);
                    b_next     = W'(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
                    mode_next  = s_tuser;
                    k_next     = '0;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (a_reg == '0 || b_reg == '0)
                begin
                    g_next = gcd_val;
                    if (mode_reg == MODE_GCD)
                    begin
                        res_next   = gcd_val;
                        ovf_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (opa_reg == '0 || opb_reg == '0)
                    begin
                        res_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        a_next     = opa_reg;
                        b_next     = '0;
                        cnt_next   = KW'(W);
                        state_next = S_DIV;
                    end
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (alu_carry)
                begin
                    // both odd, a >= b: the difference is even
                    a_next = alu_sum[W-1:0] >> 1;
                end
                else
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            S_DIV:
            begin
                if (alu_carry)
                begin
                    b_next = alu_sum[W-1:0];
                    a_next = {a_reg[W-2:0], 1'b1};
                end
                else
                begin
                    b_next = alu_a[W-1:0];
                    a_next = {a_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    // quotient stays in a as the multiplier
                    b_next     = '0;
                    cnt_next   = KW'(W);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                b_next   = mul_sum[W:1];
                a_next   = {mul_sum[0], a_reg[W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    ovf_next   = (mul_sum[W:1] != '0);
                    res_next   = (mul_sum[W:1] != '0) ? '1 : {mul_sum[0], a_reg[W-1:1]};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_data_next = DATA_WIDTH'(res_reg);
                    out_ovf_next  = ovf_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        g_reg        <= g_next;
        res_reg      <= res_next;
        ovf_reg      <= ovf_next;
        mode_reg     <= mode_next;
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        out_ovf_reg  <= out_ovf_next;
    end

endmodule

`default_nettype wire

// ===== rtl/gcl_checker.sv =====
// ----------------------------------------------------------------------------
// gcl_checker
// Port-level assertions for the gcd / lcm unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [2*gcl_pkg::DATA_WIDTH-1:0] s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [gcl_pkg::DATA_WIDTH-1:0]   m_tdata,
    input  wire logic                           m_tuser
);
    import gcl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // a result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while still busy");

    // a saturated multiple has its low bits all set
    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[3:0] == 4'hF)
        else $error("overflow without saturated result");

endmodule

bind gcd_lcm_unit gcl_checker u_gcl_checker (.*);

`default_nettype wire

// ===== sim/gcd_lcm_unit_tb.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit_tb
// Self-checking bench for the gcd / lcm unit. Directed corner items come first,
// then random operand pairs with shared factors, small and full-width values.
// Every accepted item is run through an exact Euclid-based predictor. Each
// result is checked against the oldest awaited one, while both stream sides
// stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_lcm_unit_tb;

    import gcl_pkg::*;

    localparam int RANDOM_ITEMS = 1730;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 250;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic  mode;
        word_t first;
        word_t second;
    } operand_pair_t;

    typedef struct packed {
        word_t value;
        logic  ovf;
    } gcd_lcm_t;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [2*DATA_WIDTH-1:0] s_tdata  = '0;
    logic                    s_tuser  = MODE_GCD;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [DATA_WIDTH-1:0]   m_tdata;
    logic                    m_tuser;

    operand_pair_t pending_pairs[$];
    gcd_lcm_t      awaited_results[$];
    operand_pair_t next_pair;
    operand_pair_t taken_pair;
    gcd_lcm_t      awaited;
    int            fail_count    = 0;
    int            results_seen  = 0;
    int            cycle_count   = 0;

    gcd_lcm_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic gcd_lcm_t compute_gcd_lcm(operand_pair_t p);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] g;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] mask;
        gcd_lcm_t    res;
        mask = 64'h0000_0000_FFFF_FFFF;
        a    = {32'd0, p.first};
        b    = {32'd0, p.second};
        res  = '0;
        g    = a;
        r    = b;
        while (r != 0)
        begin
            t = g % r;
            g = r;
            r = t;
        end
        if (p.mode == MODE_GCD)
            res.value = g[31:0];
        else if (a == 0 || b == 0)
            res.value = '0;
        else
        begin
            t = a / g;
            if (t > mask / b)
            begin
                res.value = '1;
                res.ovf   = 1'b1;
            end
            else
            begin
                r         = t * b;
                res.value = r[31:0];
            end
        end
        return res;
    endfunction

    function automatic operand_pair_t make_pair(logic mode, word_t a, word_t b);
        operand_pair_t p;
        p.mode   = mode;
        p.first  = a;
        p.second = b;
        return p;
    endfunction

    // mix of specials, narrow and full-width values
    function automatic word_t rand_operand();
        word_t v;
        case ($urandom_range(7))
            0: v = word_t'($urandom_range(2));
            1: v = 32'hFFFF_FFFF - $urandom_range(2);
            2, 3: v = $urandom;
            4: v = $urandom_range(65535);
            default: v = $urandom >> $urandom_range(31);
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("mismatch: %s got %0h expected %0h", what, got, want);
    endtask

    // sender: holds an item until taken, idles at random except for a long burst
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= MODE_GCD;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                taken_pair = make_pair(s_tuser, s_tdata[DATA_WIDTH-1:0],
                                       s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
                awaited_results.push_back(compute_gcd_lcm(taken_pair));
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_pairs.size() != 0 &&
                    !((pending_pairs.size() < 600 || pending_pairs.size() > 900) &&
                      $urandom_range(99) < 22))
                begin
                    next_pair = pending_pairs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_pair.second, next_pair.first};
                    s_tuser  <= next_pair.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each result against the oldest awaited one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with nothing awaited",
                                    64'({m_tdata, m_tuser}), 64'd0);
                else
                begin
                    awaited = awaited_results.pop_front();
                    if (m_tdata !== awaited.value)
                        report_mismatch("result_value", 64'(m_tdata),
                                        64'(awaited.value));
                    if (m_tuser !== awaited.ovf)
                        report_mismatch("overflow", 64'(m_tuser), 64'(awaited.ovf));
                end
                results_seen++;
            end
            m_tready <= !((results_seen < 850 || results_seen > 1150) &&
                          $urandom_range(99) < 22);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        word_t g;
        word_t a;
        word_t b;
        logic  mode;

        // divisor corners
        pending_pairs.push_back(make_pair(MODE_GCD, 0, 0));
        pending_pairs.push_back(make_pair(MODE_GCD, 0, 32'd12345));
        pending_pairs.push_back(make_pair(MODE_GCD, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(make_pair(MODE_GCD, 1, 32'hFFFF_FFFF));
        pending_pairs.push_back(make_pair(MODE_GCD, 32'hDEAD_BEEF, 1));
        pending_pairs.push_back(make_pair(MODE_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_pairs.push_back(make_pair(MODE_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
        pending_pairs.push_back(make_pair(MODE_GCD, 32'h8000_0000, 32'h0001_0000));
        pending_pairs.push_back(make_pair(MODE_GCD, 32'd1836311903, 32'd2971215073));
        pending_pairs.push_back(make_pair(MODE_GCD, 32'd360, 32'd84));
        // multiple corners, overflow boundary included
        pending_pairs.push_back(make_pair(MODE_LCM, 0, 0));
        pending_pairs.push_back(make_pair(MODE_LCM, 0, 32'hFFFF_FFFF));
        pending_pairs.push_back(make_pair(MODE_LCM, 32'd77, 0));
        pending_pairs.push_back(make_pair(MODE_LCM, 1, 32'hFFFF_FFFF));
        pending_pairs.push_back(make_pair(MODE_LCM, 32'hCAFE_F00D, 1));
        pending_pairs.push_back(make_pair(MODE_LCM, 1, 1));
        pending_pairs.push_back(make_pair(MODE_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_pairs.push_back(make_pair(MODE_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
        pending_pairs.push_back(make_pair(MODE_LCM, 32'd65535, 32'd65537));
        pending_pairs.push_back(make_pair(MODE_LCM, 32'd65536, 32'd65537));
        pending_pairs.push_back(make_pair(MODE_LCM, 32'h8000_0000, 32'd2));
        pending_pairs.push_back(make_pair(MODE_LCM, 32'h8000_0000, 32'd3));
        pending_pairs.push_back(make_pair(MODE_LCM, 32'd4, 32'd6));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            mode = $urandom_range(1) ? MODE_LCM : MODE_GCD;
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    // shared factor keeps the divisor nontrivial
                    g = $urandom_range(1, 65535) >> $urandom_range(15);
                    a = g * $urandom_range(0, 65535);
                    b = g * ($urandom_range(0, 65535) >> $urandom_range(15));
                end
                3:
                begin
                    b = $urandom >> $urandom_range(31);
                    a = b * $urandom_range(1, 8);
                end
                default:
                begin
                    a = rand_operand();
                    b = rand_operand();
                end
            endcase
            if ($urandom_range(1))
                pending_pairs.push_back(make_pair(mode, a, b));
            else
                pending_pairs.push_back(make_pair(mode, b, a));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || s_tvalid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
